// ----- rtl/arpc_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and hash helpers for the arp cache insert core
package arpc_pkg;

  // table size, a power of two
  localparam int TABLE_SLOTS = 256;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);

  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int IFACE_W = 4;
  localparam int STAT_W  = 2;
  localparam int IDX_W   = 8;
  localparam int PAY_W   = MAC_W + IFACE_W;

  // one-at-a-time shift amounts
  localparam int SH_MIX_L  = 10;
  localparam int SH_MIX_R  = 6;
  localparam int SH_FIN1_L = 3;
  localparam int SH_FIN1_R = 11;
  localparam int SH_FIN2_L = 15;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED = 2'd0,
    STAT_PRESENT  = 2'd1,
    STAT_FULL     = 2'd2
  } arpc_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_FIN1,
    ST_FIN2,
    ST_READ,
    ST_CHECK
  } arpc_state_t;

  typedef struct packed {
    logic         load;
    logic         hash_step;
    logic [1:0]   byte_sel;
    logic         fin1;
    logic         fin2;
    logic         advance;
    logic         write;
    logic         emit;
    arpc_status_t status;
  } arpc_cmd_t;

  typedef struct packed {
    logic slot_empty;
    logic ip_match;
    logic last_probe;
  } arpc_sts_t;

  // one byte round of the hash
  function automatic logic [IP_W-1:0] oat_mix(input logic [IP_W-1:0] h,
                                              input logic [7:0] b);
    logic [IP_W-1:0] t;
    logic [IP_W-1:0] u;
    t = h + {{(IP_W-8){1'b0}}, b};
    u = t + (t << SH_MIX_L);
    return u ^ (u >> SH_MIX_R);
  endfunction

  // first part of the final avalanche
  function automatic logic [IP_W-1:0] oat_fin1(input logic [IP_W-1:0] h);
    logic [IP_W-1:0] t;
    t = h + (h << SH_FIN1_L);
    return t ^ (t >> SH_FIN1_R);
  endfunction

  // last part of the final avalanche
  function automatic logic [IP_W-1:0] oat_fin2(input logic [IP_W-1:0] h);
    return h + (h << SH_FIN2_L);
  endfunction

endpackage

// ----- rtl/arpc_ctrl.sv -----
`timescale 1ns / 1ps
// controller: sequences hashing and the probe loop
module arpc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  arpc_pkg::arpc_sts_t sts,
  output arpc_pkg::arpc_cmd_t cmd
);

  arpc_pkg::arpc_state_t state_r, state_nxt;
  logic [1:0] byte_cnt_r, byte_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= arpc_pkg::ST_IDLE;
      byte_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      byte_cnt_r <= byte_cnt_nxt;
    end
  end

  assign busy = (state_r != arpc_pkg::ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    byte_cnt_nxt  = byte_cnt_r;
    cmd           = '0;
    cmd.byte_sel  = byte_cnt_r;
    cmd.status    = arpc_pkg::STAT_INSERTED;
    unique case (state_r)
      arpc_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          byte_cnt_nxt = '0;
          state_nxt    = arpc_pkg::ST_HASH;
        end
      end
      arpc_pkg::ST_HASH: begin
        cmd.hash_step = 1'b1;
        byte_cnt_nxt  = byte_cnt_r + 2'd1;
        if (byte_cnt_r == 2'd3) begin
          state_nxt = arpc_pkg::ST_FIN1;
        end
      end
      arpc_pkg::ST_FIN1: begin
        cmd.fin1  = 1'b1;
        state_nxt = arpc_pkg::ST_FIN2;
      end
      arpc_pkg::ST_FIN2: begin
        cmd.fin2  = 1'b1;
        state_nxt = arpc_pkg::ST_READ;
      end
      // wait for the registered table read
      arpc_pkg::ST_READ: begin
        state_nxt = arpc_pkg::ST_CHECK;
      end
      arpc_pkg::ST_CHECK: begin
        if (sts.slot_empty) begin
          cmd.write  = 1'b1;
          cmd.emit   = 1'b1;
          cmd.status = arpc_pkg::STAT_INSERTED;
          state_nxt  = arpc_pkg::ST_IDLE;
        end else if (sts.ip_match) begin
          cmd.emit   = 1'b1;
          cmd.status = arpc_pkg::STAT_PRESENT;
          state_nxt  = arpc_pkg::ST_IDLE;
        end else if (sts.last_probe) begin
          cmd.emit   = 1'b1;
          cmd.status = arpc_pkg::STAT_FULL;
          state_nxt  = arpc_pkg::ST_IDLE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = arpc_pkg::ST_READ;
        end
      end
      default: begin
        state_nxt = arpc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/arpc_dpath.sv -----
`timescale 1ns / 1ps
// datapath: request registers, hash, slot tables and result register
module arpc_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  arpc_pkg::arpc_cmd_t               cmd,
  output arpc_pkg::arpc_sts_t               sts,
  input  logic [arpc_pkg::IP_W-1:0]         in_ip_address,
  input  logic [arpc_pkg::MAC_W-1:0]        in_mac_address,
  input  logic [arpc_pkg::IFACE_W-1:0]      in_iface_id,
  output logic                              out_valid,
  output logic [arpc_pkg::STAT_W-1:0]       out_status,
  output logic [arpc_pkg::IDX_W-1:0]        out_slot_index
);

  localparam logic [arpc_pkg::SLOT_W-1:0] LAST_SLOT =
    arpc_pkg::SLOT_W'(arpc_pkg::TABLE_SLOTS - 1);

  logic [arpc_pkg::IP_W-1:0]    ip_r;
  logic [arpc_pkg::MAC_W-1:0]   mac_r;
  logic [arpc_pkg::IFACE_W-1:0] iface_r;
  logic [arpc_pkg::IP_W-1:0]    hash_r;
  logic [arpc_pkg::IP_W-1:0]    hash_fin;
  logic [arpc_pkg::SLOT_W-1:0]  idx_r;
  logic [arpc_pkg::SLOT_W-1:0]  start_r;
  logic [arpc_pkg::SLOT_W-1:0]  pcnt_r;
  logic [arpc_pkg::SLOT_W-1:0]  idx_inc;

  logic                          valid_r [arpc_pkg::TABLE_SLOTS];
  logic [arpc_pkg::IP_W-1:0]     ip_mem  [arpc_pkg::TABLE_SLOTS];
  logic [arpc_pkg::PAY_W-1:0]    pay_mem [arpc_pkg::TABLE_SLOTS];
  logic [arpc_pkg::IP_W-1:0]     ip_rd_r;
  logic                          vld_rd_r;

  logic                          out_valid_r;
  arpc_pkg::arpc_status_t        out_status_r;
  logic [arpc_pkg::IDX_W-1:0]    out_slot_r;

  assign hash_fin = arpc_pkg::oat_fin2(hash_r);
  assign idx_inc  = (idx_r == LAST_SLOT) ? '0 : idx_r + 1'b1;

  // request, hash and probe position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ip_r    <= in_ip_address;
      mac_r   <= in_mac_address;
      iface_r <= in_iface_id;
      hash_r  <= '0;
    end else if (cmd.hash_step) begin
      hash_r <= arpc_pkg::oat_mix(hash_r, ip_r[{cmd.byte_sel, 3'b000} +: 8]);
    end else if (cmd.fin1) begin
      hash_r <= arpc_pkg::oat_fin1(hash_r);
    end
    if (cmd.fin2) begin
      // table size is a power of two: modulo is the low bits
      idx_r   <= hash_fin[arpc_pkg::SLOT_W-1:0];
      start_r <= hash_fin[arpc_pkg::SLOT_W-1:0];
      pcnt_r  <= '0;
    end else if (cmd.advance) begin
      idx_r  <= idx_inc;
      pcnt_r <= pcnt_r + 1'b1;
    end
  end

  // valid marks, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < arpc_pkg::TABLE_SLOTS; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (cmd.write) begin
      valid_r[idx_r] <= 1'b1;
    end
  end

  // slot stores, registered read at the probe position
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      ip_mem[idx_r]  <= ip_r;
      pay_mem[idx_r] <= {mac_r, iface_r};
    end
    ip_rd_r  <= ip_mem[idx_r];
    vld_rd_r <= valid_r[idx_r];
  end

  assign sts.slot_empty = !vld_rd_r;
  assign sts.ip_match   = (ip_rd_r == ip_r);
  assign sts.last_probe = (pcnt_r == LAST_SLOT);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
    if (cmd.emit) begin
      out_status_r <= cmd.status;
      out_slot_r   <= (cmd.status == arpc_pkg::STAT_FULL) ?
                      arpc_pkg::IDX_W'(start_r) : arpc_pkg::IDX_W'(idx_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  a_write_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> (!vld_rd_r && cmd.emit && cmd.status == arpc_pkg::STAT_INSERTED))
    else $error("write into an occupied slot");

  a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.status == arpc_pkg::STAT_FULL) |->
      (pcnt_r == LAST_SLOT && vld_rd_r && ip_rd_r != ip_r))
    else $error("full reported before the whole table was probed");

  a_written_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |=> valid_r[$past(idx_r)])
    else $error("written slot not marked valid");

endmodule

// ----- rtl/arp_cache_hash_insert_core.sv -----
`timescale 1ns / 1ps
// top level of the arp cache insert core: controller plus datapath
//
//   channel   ports                                           handshake
//   input     in_ip_address, in_mac_address, in_iface_id      start & !busy
//   result    out_status, out_slot_index                      out_valid strobe
//
// an insert runs from accept through 4 hash byte rounds and 2 final
// rounds, then probes p slots (1 to 256), each a registered read of the
// ip store followed by a check, before the next accept is possible.
// the result beat shows for one cycle in the cycle the core goes idle.
// synchronous reset clears the controller, the result strobe and all slot
// valid marks at once; no clearing pass. the receiver cannot stall.
module arp_cache_hash_insert_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [arpc_pkg::IP_W-1:0]         in_ip_address,
  input  logic [arpc_pkg::MAC_W-1:0]        in_mac_address,
  input  logic [arpc_pkg::IFACE_W-1:0]      in_iface_id,
  output logic                              out_valid,
  output logic [arpc_pkg::STAT_W-1:0]       out_status,
  output logic [arpc_pkg::IDX_W-1:0]        out_slot_index
);

  arpc_pkg::arpc_cmd_t cmd;
  arpc_pkg::arpc_sts_t sts;

  arpc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  arpc_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_ip_address  (in_ip_address),
    .in_mac_address (in_mac_address),
    .in_iface_id    (in_iface_id),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_slot_index (out_slot_index)
  );

endmodule
